/* src/awma_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the adaptive window moving average block.
// No dependencies; used by awma_ctrl, awma_dp and the top level.
package awma_pkg;

	localparam int SAMPLE_W    = 8;
	localparam int OP_W        = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_QUERY = 2'd0,
		OP_PUSH  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_SUM,
		ST_MSTART,
		ST_DIVM,
		ST_RES,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic take_in;
		logic div_step;
		logic set_win;
		logic acc_step;
		logic div_start_m;
		logic set_mean;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic in_clear;
		logic div_last;
		logic win_empty;
		logic sum_last;
		logic out_free;
	} sts_t;

endpackage

/* src/awma_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the adaptive window moving average block.
// Depends on awma_pkg; drives the datapath awma_dp through command and status structs.
module awma_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  awma_pkg::sts_t  sts,
	output awma_pkg::cmd_t  cmd
);

	awma_pkg::state_t state_q;
	awma_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= awma_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			awma_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_nxt   = sts.in_clear ? awma_pkg::ST_DONE : awma_pkg::ST_WIN;
				end
			end
			awma_pkg::ST_WIN: begin
				cmd.set_win = 1'b1;
				state_nxt   = sts.win_empty ? awma_pkg::ST_DONE : awma_pkg::ST_SUM;
			end
			awma_pkg::ST_SUM: begin
				cmd.acc_step = 1'b1;
				if (sts.sum_last) begin
					state_nxt = awma_pkg::ST_MSTART;
				end
			end
			awma_pkg::ST_MSTART: begin
				cmd.div_start_m = 1'b1;
				state_nxt       = awma_pkg::ST_DIVM;
			end
			awma_pkg::ST_DIVM: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = awma_pkg::ST_RES;
				end
			end
			awma_pkg::ST_RES: begin
				cmd.set_mean = 1'b1;
				state_nxt    = awma_pkg::ST_DONE;
			end
			awma_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = awma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = awma_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* src/awma_dp.sv */
`timescale 1ns / 1ps
// Datapath: sample history, floor register, reciprocal multiplier for the window,
// accumulator, restoring divider for the mean and output register.
// Depends on awma_pkg; sequenced by awma_ctrl.
module awma_dp #(
	parameter int DEPTH = 10,
	parameter int STEP  = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  awma_pkg::cmd_t                      cmd,
	output awma_pkg::sts_t                      sts,
	input  logic [awma_pkg::OP_W-1:0]           in_op,
	input  logic [awma_pkg::SAMPLE_W-1:0]       in_sample,
	input  logic [awma_pkg::SAMPLE_W-1:0]       in_max,
	input  logic                                cfg_valid,
	input  logic [awma_pkg::SAMPLE_W-1:0]       cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [awma_pkg::SAMPLE_W-1:0]       out_data
);

	localparam int SW     = awma_pkg::SAMPLE_W;
	localparam int SUM_W  = $clog2(DEPTH * 255 + 1);
	localparam int DIV_W  = (SUM_W > SW) ? SUM_W : SW;
	localparam int WIN_W  = $clog2(DEPTH + 1);
	localparam int DVS_W  = WIN_W;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam int STEP_L = $clog2(STEP);
	localparam int RCP_S  = SW + STEP_L;
	localparam int RCP_M  = ((1 << RCP_S) + STEP - 1) / STEP;
	localparam int RCP_W  = $clog2(RCP_M + 1);
	localparam int PRD_W  = SW + RCP_W;

	logic [SW-1:0]    floor_q;
	logic [SW-1:0]    hist_q [DEPTH];
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIN_W-1:0] w_q;
	logic [WIN_W-1:0] k_q;
	logic [SUM_W-1:0] acc_q;
	logic [SW-1:0]    res_q;
	logic             out_valid_q;
	logic [SW-1:0]    out_data_q;

	logic [SW:0]      diff;
	logic [SW-1:0]    dvd;
	logic [PRD_W-1:0] prod;
	logic [SW-1:0]    q_step;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DIV_W-1:0] wdiff;

	assign diff    = {1'b0, in_max} - {1'b0, floor_q};
	assign dvd     = diff[SW] ? '0 : diff[SW-1:0];
	assign prod    = PRD_W'(dvd) * PRD_W'(RCP_M);
	assign q_step  = SW'(prod >> RCP_S);
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign ge      = (shifted >= {1'b0, dvs_q});
	assign wdiff   = DIV_W'(DEPTH) - quo_q;

	assign sts.in_clear  = (in_op == awma_pkg::OP_CLEAR);
	assign sts.div_last  = (cnt_q == CNT_W'(1));
	assign sts.win_empty = (quo_q >= DIV_W'(DEPTH));
	assign sts.sum_last  = (k_q == (w_q - WIN_W'(1)));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= '0;
		end else if (cfg_valid) begin
			floor_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				hist_q[k] <= '0;
			end
		end else if (cmd.take_in) begin
			case (in_op)
				awma_pkg::OP_PUSH: begin
					for (int k = DEPTH - 1; k > 0; k--) begin
						hist_q[k] <= hist_q[k-1];
					end
					hist_q[0] <= in_sample;
				end
				awma_pkg::OP_CLEAR: begin
					for (int k = 0; k < DEPTH; k++) begin
						hist_q[k] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start_m) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			quo_q <= DIV_W'(q_step);
		end else if (cmd.div_start_m) begin
			quo_q <= DIV_W'(acc_q);
			rem_q <= '0;
			dvs_q <= DVS_W'(w_q);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_win) begin
			w_q   <= wdiff[WIN_W-1:0];
			k_q   <= '0;
			acc_q <= '0;
		end else if (cmd.acc_step) begin
			acc_q <= acc_q + SUM_W'(hist_q[k_q[IDX_W-1:0]]);
			k_q   <= k_q + WIN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in && sts.in_clear) begin
			res_q <= '0;
		end else if (cmd.set_win && sts.win_empty) begin
			res_q <= hist_q[0];
		end else if (cmd.set_mean) begin
			res_q <= quo_q[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (cnt_q != '0))
		else $error("divider stepped with no steps left");

	a_win_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.set_win && !sts.win_empty) |=> (w_q != '0 && w_q <= WIN_W'(DEPTH)))
		else $error("window length out of range");

	a_sum_index: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_step |-> (k_q < w_q))
		else $error("accumulation beyond the window");

endmodule

/* src/adaptive_window_moving_average_top.sv */
`timescale 1ns / 1ps
// Top level of the adaptive window moving average block.
// Depends on awma_pkg, awma_ctrl and awma_dp.
//
// One item is worked on at a time and gives one result beat. The divider width
// is the bit width of DEPTH*255, at least 8 (12 at the defaults). A query passes
// through the states WIN, SUM, MSTART, DIVM and RES before its beat is offered; a
// query whose window comes out empty goes from WIN straight to DONE, and a clear
// goes from acceptance straight to DONE. The input is ready again once the beat is
// offered, later only while the previous beat still waits in the output register.
// The window length comes from a reciprocal multiplication by STEP in the
// accepting cycle; the rest of the time is set by the accumulator adding one
// history entry per cycle and by the restoring divider for the mean, one
// quotient bit per cycle. A finished result waits in the output register while
// the next item is accepted; the floor register may be written at any time
// through the configuration channel.
module adaptive_window_moving_average_top #(
	parameter int DEPTH = 10,
	parameter int STEP  = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Fields from bit 0: sample [7:0], peak_level [15:8].
	input  logic [awma_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// Fields from bit 0: operation [1:0].
	input  logic [awma_pkg::OP_W-1:0]            s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Fields from bit 0: filtered [7:0].
	output logic [awma_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [awma_pkg::SAMPLE_W-1:0]        cfg_data
);

	awma_pkg::cmd_t cmd;
	awma_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	awma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	awma_dp #(
		.DEPTH (DEPTH),
		.STEP  (STEP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (s_axis_tuser),
		.in_sample (s_axis_tdata[7:0]),
		.in_max    (s_axis_tdata[15:8]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for adaptive_window_moving_average_top: directed and random tests
// on both streams, with a predictor of the sample history and the floor register.
// Depends on awma_pkg and the RTL of the block.
module tb_top;

	localparam int DEPTH       = 10;
	localparam int STEP        = 10;
	localparam int SETTLE_CYC  = 60;
	localparam int TIMEOUT_NS  = 2_000_000;
	localparam int SAMPLE_W    = awma_pkg::SAMPLE_W;
	localparam int OP_W        = awma_pkg::OP_W;
	localparam int IN_TDATA_W  = awma_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = awma_pkg::OUT_TDATA_W;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	logic                   clk            = 1'b0;
	logic                   arst_n         = 1'b0;
	logic                   s_axis_tvalid  = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
	logic [OP_W-1:0]        s_axis_tuser   = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid      = 1'b0;
	logic                   cfg_ready;
	logic [SAMPLE_W-1:0]    cfg_data       = '0;

	logic [SAMPLE_W-1:0] history_m [DEPTH];
	logic [SAMPLE_W-1:0] floor_m;
	logic [SAMPLE_W-1:0] filtered_q [$];

	bit in_held      = 1'b0;
	bit send_no_idle = 1'b0;
	bit recv_no_idle = 1'b0;
	int error_count  = 0;
	int items_sent   = 0;
	int beats_seen   = 0;
	int floor_writes = 0;

	adaptive_window_moving_average_top #(
		.DEPTH(DEPTH),
		.STEP (STEP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap(bit no_idle);
		return no_idle ? 0 : int'($urandom_range(0, 15));
	endfunction

	// Updates the modelled history for one item and returns the filtered value.
	function automatic logic [SAMPLE_W-1:0] predict_filtered(logic [OP_W-1:0] op,
			logic [SAMPLE_W-1:0] sample, logic [SAMPLE_W-1:0] peak_level);
		int d;
		int q;
		int w;
		int sum;
		if (op == awma_pkg::OP_CLEAR) begin
			for (int k = 0; k < DEPTH; k++) history_m[k] = '0;
			return '0;
		end
		if (op == awma_pkg::OP_PUSH) begin
			for (int k = DEPTH - 1; k > 0; k--) history_m[k] = history_m[k-1];
			history_m[0] = sample;
		end
		d = int'(peak_level) - int'(floor_m);
		q = d / STEP;
		w = DEPTH - q;
		if (w > DEPTH) w = DEPTH;
		if (w <= 0) return history_m[0];
		sum = 0;
		for (int k = 0; k < w; k++) sum += int'(history_m[k]);
		return SAMPLE_W'(sum / w);
	endfunction

	task automatic send_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sample,
			logic [SAMPLE_W-1:0] peak_level);
		int gap;
		gap = draw_gap(send_no_idle);
		if (gap != 0) begin
			if (in_held) s_axis_tvalid <= 1'b0;
			in_held = 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {peak_level, sample};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		in_held = 1'b1;
		filtered_q.push_back(predict_filtered(op, sample, peak_level));
		items_sent++;
	endtask

	// Lowers the input stream and waits until every expected beat has arrived.
	task automatic wait_idle();
		if (in_held) s_axis_tvalid <= 1'b0;
		in_held = 1'b0;
		@(posedge clk);
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_floor(logic [SAMPLE_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		floor_m = value;
		floor_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: draws a stall before each beat, then checks it against the oldest expectation.
	initial begin
		int gap;
		forever begin
			gap = draw_gap(recv_no_idle);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			beats_seen++;
			if (filtered_q.size() == 0) begin
				$error("filtered: expected none, actual %0d", m_axis_tdata);
				error_count++;
			end else begin
				logic [SAMPLE_W-1:0] want;
				want = filtered_q.pop_front();
				if (m_axis_tdata !== want) begin
					$error("filtered: expected %0d, actual %0d", want, m_axis_tdata);
					error_count++;
				end
			end
		end
	end

	task automatic test_after_reset();
		send_item(awma_pkg::OP_QUERY, 8'hA5, 8'd0);
		send_item(awma_pkg::OP_QUERY, 8'h5A, 8'd255);
	endtask

	task automatic test_push_extremes();
		send_item(awma_pkg::OP_PUSH, 8'd255, 8'd0);
		send_item(awma_pkg::OP_PUSH, 8'd255, 8'd9);
		send_item(awma_pkg::OP_PUSH, 8'd0, 8'd10);
		send_item(awma_pkg::OP_PUSH, 8'd255, 8'd99);
		send_item(awma_pkg::OP_PUSH, 8'd1, 8'd100);
		send_item(awma_pkg::OP_PUSH, 8'd254, 8'd255);
		for (int k = 0; k < 5; k++) send_item(awma_pkg::OP_PUSH, 8'd255, 8'd0);
		send_item(awma_pkg::OP_QUERY, 8'd0, 8'd89);
		send_item(awma_pkg::OP_QUERY, 8'd0, 8'd90);
	endtask

	task automatic test_clear_and_spare();
		send_item(awma_pkg::OP_CLEAR, 8'd77, 8'd255);
		send_item(awma_pkg::OP_QUERY, 8'd0, 8'd0);
		send_item(awma_pkg::OP_PUSH, 8'd200, 8'd50);
		send_item(OP_SPARE, 8'd13, 8'd0);
		send_item(OP_SPARE, 8'd13, 8'd255);
	endtask

	task automatic test_floor_extremes();
		write_floor(8'd255);
		send_item(awma_pkg::OP_PUSH, 8'd128, 8'd0);
		send_item(awma_pkg::OP_QUERY, 8'd0, 8'd255);
		send_item(awma_pkg::OP_QUERY, 8'd0, 8'd246);
		write_floor(8'd128);
		send_item(awma_pkg::OP_PUSH, 8'd3, 8'd228);
		send_item(awma_pkg::OP_QUERY, 8'd0, 8'd227);
		send_item(awma_pkg::OP_QUERY, 8'd0, 8'd119);
	endtask

	task automatic test_random_phase(int count, logic [SAMPLE_W-1:0] floor_val, bit burst);
		int pick;
		int t;
		logic [OP_W-1:0] op;
		logic [SAMPLE_W-1:0] sample;
		write_floor(floor_val);
		send_no_idle = burst;
		recv_no_idle = burst;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) op = awma_pkg::OP_PUSH;
			else if (pick < 88) op = awma_pkg::OP_QUERY;
			else if (pick < 95) op = awma_pkg::OP_CLEAR;
			else op = OP_SPARE;
			pick = $urandom_range(0, 9);
			if (pick == 0) sample = 8'd0;
			else if (pick == 1) sample = 8'd255;
			else sample = SAMPLE_W'($urandom_range(0, 255));
			if ($urandom_range(0, 9) < 4) begin
				t = $urandom_range(0, 255);
			end else begin
				t = int'(floor_m) + (int'($urandom_range(0, 24)) - 12) * STEP
					+ int'($urandom_range(0, 2)) - 1;
				if (t < 0) t = 0;
				if (t > 255) t = 255;
			end
			send_item(op, sample, SAMPLE_W'(t));
		end
		send_no_idle = 1'b0;
		recv_no_idle = 1'b0;
	endtask

	initial begin
		for (int k = 0; k < DEPTH; k++) history_m[k] = '0;
		floor_m = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_push_extremes();
		test_clear_and_spare();
		test_floor_extremes();
		test_random_phase(100, 8'd0, 1'b0);
		test_random_phase(60, 8'd255, 1'b0);
		test_random_phase(100, SAMPLE_W'($urandom_range(0, 255)), 1'b0);
		test_random_phase(80, SAMPLE_W'($urandom_range(0, 255)), 1'b1);
		test_random_phase(60, 8'd100, 1'b0);

		wait_idle();
		$display("Sent %0d items and checked %0d result beats across %0d floor settings.",
			items_sent, beats_seen, floor_writes);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule
